[hdl/fehm_pkg.sv]
// shared types, constants and palette table for the fire effect heat map
`timescale 1ns / 1ps

package fehm_pkg;

    localparam int HEAT_W  = 6;
    localparam int PIX_W   = 11;
    localparam int DECAY_W = 3;
    localparam int COLOR_W = 8;

    localparam logic [HEAT_W-1:0] HEAT_MAX = HEAT_W'(36);

    localparam int MAP_WIDTH_DEF  = 60;
    localparam int MAP_HEIGHT_DEF = 30;
    localparam int DECAY_SPAN_DEF = 5;

    localparam logic CMD_PROPAGATE = 1'b0;
    localparam logic CMD_READ      = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [PIX_W-1:0]   pixel_pos;
        logic [DECAY_W-1:0] decay;
    } in_beat_t;

    typedef struct packed {
        logic [HEAT_W-1:0]  heat;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } out_beat_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } fehm_state_t;

    // where the heat of the addressed cell comes from
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_FULL,
        SRC_ZERO
    } fehm_src_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic commit;
    } fehm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic out_free;
    } fehm_stat_t;

    function automatic rgb_t palette_lookup(input logic [HEAT_W-1:0] heat);
        rgb_t c;
        case (heat)
            6'd0:    c = '{8'd7,   8'd7,   8'd7};
            6'd1:    c = '{8'd31,  8'd7,   8'd7};
            6'd2:    c = '{8'd47,  8'd15,  8'd7};
            6'd3:    c = '{8'd71,  8'd15,  8'd7};
            6'd4:    c = '{8'd87,  8'd23,  8'd7};
            6'd5:    c = '{8'd103, 8'd31,  8'd7};
            6'd6:    c = '{8'd119, 8'd31,  8'd7};
            6'd7:    c = '{8'd143, 8'd39,  8'd7};
            6'd8:    c = '{8'd159, 8'd47,  8'd7};
            6'd9:    c = '{8'd175, 8'd63,  8'd7};
            6'd10:   c = '{8'd191, 8'd71,  8'd7};
            6'd11:   c = '{8'd199, 8'd71,  8'd7};
            6'd12:   c = '{8'd223, 8'd79,  8'd7};
            6'd13:   c = '{8'd223, 8'd87,  8'd7};
            6'd14:   c = '{8'd223, 8'd87,  8'd7};
            6'd15:   c = '{8'd215, 8'd95,  8'd7};
            6'd16:   c = '{8'd215, 8'd95,  8'd7};
            6'd17:   c = '{8'd215, 8'd103, 8'd15};
            6'd18:   c = '{8'd207, 8'd111, 8'd15};
            6'd19:   c = '{8'd207, 8'd119, 8'd15};
            6'd20:   c = '{8'd207, 8'd127, 8'd15};
            6'd21:   c = '{8'd207, 8'd135, 8'd23};
            6'd22:   c = '{8'd199, 8'd135, 8'd23};
            6'd23:   c = '{8'd199, 8'd143, 8'd23};
            6'd24:   c = '{8'd199, 8'd151, 8'd31};
            6'd25:   c = '{8'd191, 8'd159, 8'd31};
            6'd26:   c = '{8'd191, 8'd159, 8'd31};
            6'd27:   c = '{8'd191, 8'd167, 8'd39};
            6'd28:   c = '{8'd191, 8'd167, 8'd39};
            6'd29:   c = '{8'd191, 8'd175, 8'd47};
            6'd30:   c = '{8'd183, 8'd175, 8'd47};
            6'd31:   c = '{8'd183, 8'd183, 8'd47};
            6'd32:   c = '{8'd183, 8'd183, 8'd55};
            6'd33:   c = '{8'd207, 8'd207, 8'd111};
            6'd34:   c = '{8'd223, 8'd223, 8'd159};
            6'd35:   c = '{8'd239, 8'd239, 8'd199};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

endpackage

[hdl/fehm_ctrl.sv]
// controller state machine: clearing pass, item accept and commit sequencing
`timescale 1ns / 1ps

module fehm_ctrl
    import fehm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  fehm_stat_t stat,
    output fehm_cmd_t  cmd
);

    fehm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a read waits here until the output register can take it
                if (!stat.is_read || stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[hdl/fehm_datapath.sv]
// datapath: heat memory, address and decay arithmetic, palette and output register
`timescale 1ns / 1ps

module fehm_datapath
    import fehm_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int DECAY_SPAN = DECAY_SPAN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data,
    input  fehm_cmd_t  cmd,
    output fehm_stat_t stat
);

    localparam int CELLS   = MAP_WIDTH * MAP_HEIGHT;
    // the bottom row is never written, so only the rows above it are stored
    localparam int TOP     = CELLS - MAP_WIDTH;
    localparam int ADDR_W  = $clog2(TOP);
    localparam int CELL_W  = $clog2(CELLS + 1);
    localparam int CMP_W   = ((CELL_W > PIX_W) ? CELL_W : PIX_W) + 1;
    localparam int DEC_MAX = DECAY_SPAN - 1;

    logic [HEAT_W-1:0] heat_mem [TOP];
    logic [HEAT_W-1:0] rd_data_reg;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              is_read_reg;
    fehm_src_t         src_reg;
    logic [DECAY_W-1:0] dec_reg;
    logic              wr_ok_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg;

    logic [CMP_W-1:0]   pix_ext;
    logic [CMP_W-1:0]   below;
    logic [CMP_W-1:0]   tgt;
    logic [CMP_W-1:0]   wr_full;
    logic [DECAY_W-1:0] dec_sat;
    fehm_src_t          src_in;
    logic               wr_ok_in;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [HEAT_W-1:0]  mem_wdata;
    logic [HEAT_W-1:0]  heat_src;
    logic [HEAT_W-1:0]  heat_dec;
    rgb_t               color;

    // decode of the incoming beat
    always_comb begin
        pix_ext = CMP_W'(s_data.pixel_pos);
        below   = pix_ext + CMP_W'(MAP_WIDTH);
        dec_sat = ({1'b0, s_data.decay} > (DECAY_W + 1)'(DEC_MAX)) ?
                  DECAY_W'(DEC_MAX) : s_data.decay;
        tgt     = (s_data.cmd == CMD_READ) ? pix_ext : below;
        if (tgt < CMP_W'(TOP)) begin
            src_in = SRC_MEM;
        end else if (tgt < CMP_W'(CELLS)) begin
            src_in = SRC_FULL;
        end else begin
            src_in = SRC_ZERO;
        end
        wr_ok_in = (below < CMP_W'(CELLS)) && (CMP_W'(dec_sat) <= pix_ext);
        wr_full  = pix_ext - CMP_W'(dec_sat);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            is_read_reg <= (s_data.cmd == CMD_READ);
            src_reg     <= src_in;
            dec_reg     <= dec_sat;
            wr_ok_reg   <= wr_ok_in;
            wr_addr_reg <= wr_full[ADDR_W-1:0];
        end
    end

    // clearing pass counter
    always_comb begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clear_wr) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    // heat after decay, clamped at zero
    always_comb begin
        case (src_reg)
            SRC_MEM:  heat_src = rd_data_reg;
            SRC_FULL: heat_src = HEAT_MAX;
            SRC_ZERO: heat_src = '0;
            default:  heat_src = '0;
        endcase
        heat_dec = (heat_src >= HEAT_W'(dec_reg)) ? (heat_src - HEAT_W'(dec_reg)) : '0;
    end

    // single port heat memory
    always_comb begin
        mem_re    = cmd.capture && (src_in == SRC_MEM);
        mem_we    = cmd.clear_wr || (cmd.commit && !is_read_reg && wr_ok_reg);
        mem_waddr = cmd.clear_wr ? clr_addr_reg : wr_addr_reg;
        mem_wdata = cmd.clear_wr ? '0 : heat_dec;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heat_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= heat_mem[tgt[ADDR_W-1:0]];
        end
    end

    // output register
    always_comb begin
        color        = palette_lookup(heat_src);
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.commit && is_read_reg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && is_read_reg) begin
            m_data_reg <= '{heat_src, color.red, color.green, color.blue};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.clear_last = (clr_addr_reg == ADDR_W'(TOP - 1));
    assign stat.is_read    = is_read_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

[hdl/fire_effect_heat_map.sv]
// top level of the fire effect heat map: controller plus datapath
`timescale 1ns / 1ps
//
// fire effect heat map, one flat map of MAP_WIDTH x MAP_HEIGHT heat cells (0..36)
// s_ channel: one beat per command; cmd propagate reads the cell one row below
//   pixel_pos, subtracts decay (saturated to DECAY_SPAN-1, clamped at zero) and
//   writes it to pixel_pos - decay; bottom-row, off-map and negative writes drop
// m_ channel: one beat per read command with heat and its palette rgb;
//   propagate commands produce no beat
// timing: one item at a time, set by the single memory port (read of the
//   source cell in the accept cycle, write-back or result load in execute)
// read result: loaded into the output register when the read commits in the
//   execute state after its accept, once the output register is free
// the output register decouples the sides: a new command is accepted while a
//   result waits; a second read then holds in its execute cycle until m_ready
// reset: synchronous, active low; afterwards a clearing pass zeroes the stored
//   rows, (MAP_HEIGHT-1)*MAP_WIDTH cells (1740 by default), with s_ready low;
//   the bottom row is held at full heat by address decode and never stored
//

module fire_effect_heat_map
    import fehm_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int DECAY_SPAN = DECAY_SPAN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    fehm_cmd_t  cmd;
    fehm_stat_t stat;

    // sequencing: clear, accept, execute
    fehm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memory, arithmetic and result register
    fehm_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .DECAY_SPAN (DECAY_SPAN)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

[hdl/fehm_checker.sv]
// port-level checks for the fire effect heat map, bound to the top level
`timescale 1ns / 1ps

module fehm_checker
    import fehm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input opened during clearing pass");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // heat stays in range and full heat shows white
    a_heat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.heat <= HEAT_MAX)
        else $error("heat out of range");

    a_full_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.heat == HEAT_MAX |->
            m_data.red == 8'd255 && m_data.green == 8'd255 && m_data.blue == 8'd255)
        else $error("palette mismatch at full heat");

endmodule

bind fire_effect_heat_map fehm_checker u_fehm_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the fire effect heat map: flame sweeps, reads and backpressure
`timescale 1ns / 1ps

module testbench;
    import fehm_pkg::*;

    localparam int MAP_W      = MAP_WIDTH_DEF;
    localparam int MAP_H      = MAP_HEIGHT_DEF;
    localparam int MAP_CELLS  = MAP_W * MAP_H;
    localparam int DECAY_TOP  = DECAY_SPAN_DEF - 1;
    localparam int RAND_ITEMS = 425;
    localparam int HOLD_AT    = 200;   // accepted beats before the long receiver hold-off
    localparam int HOLD_LEN   = 400;   // cycles of the hold-off
    localparam int DRAIN      = 16;    // cycles after the last result
    localparam int MAX_SHOWN  = 10;

    // flame palette, red/green/blue per heat level
    localparam logic [23:0] FLAME_RGB [0:36] = '{
        {8'd7,   8'd7,   8'd7},   {8'd31,  8'd7,   8'd7},   {8'd47,  8'd15,  8'd7},
        {8'd71,  8'd15,  8'd7},   {8'd87,  8'd23,  8'd7},   {8'd103, 8'd31,  8'd7},
        {8'd119, 8'd31,  8'd7},   {8'd143, 8'd39,  8'd7},   {8'd159, 8'd47,  8'd7},
        {8'd175, 8'd63,  8'd7},   {8'd191, 8'd71,  8'd7},   {8'd199, 8'd71,  8'd7},
        {8'd223, 8'd79,  8'd7},   {8'd223, 8'd87,  8'd7},   {8'd223, 8'd87,  8'd7},
        {8'd215, 8'd95,  8'd7},   {8'd215, 8'd95,  8'd7},   {8'd215, 8'd103, 8'd15},
        {8'd207, 8'd111, 8'd15},  {8'd207, 8'd119, 8'd15},  {8'd207, 8'd127, 8'd15},
        {8'd207, 8'd135, 8'd23},  {8'd199, 8'd135, 8'd23},  {8'd199, 8'd143, 8'd23},
        {8'd199, 8'd151, 8'd31},  {8'd191, 8'd159, 8'd31},  {8'd191, 8'd159, 8'd31},
        {8'd191, 8'd167, 8'd39},  {8'd191, 8'd167, 8'd39},  {8'd191, 8'd175, 8'd47},
        {8'd183, 8'd175, 8'd47},  {8'd183, 8'd183, 8'd47},  {8'd183, 8'd183, 8'd55},
        {8'd207, 8'd207, 8'd111}, {8'd223, 8'd223, 8'd159}, {8'd239, 8'd239, 8'd199},
        {8'd255, 8'd255, 8'd255}
    };

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW
    } rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // shadow copy of the heat map and the colors still owed by the block
    logic [HEAT_W-1:0] heat_cells [0:MAP_CELLS-1];
    out_beat_t         color_reads [$];
    in_beat_t          pending_cmds [$];

    int n_items    = 0;
    int sent_count = 0;
    int acc_count  = 0;
    int fail_count = 0;

    fire_effect_heat_map #(
        .MAP_WIDTH  (MAP_WIDTH_DEF),
        .MAP_HEIGHT (MAP_HEIGHT_DEF),
        .DECAY_SPAN (DECAY_SPAN_DEF)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // bottom row starts at full heat, everything else cold
    initial begin
        for (int i = 0; i < MAP_CELLS; i++)
            heat_cells[i] = (i >= MAP_CELLS - MAP_W) ? HEAT_MAX : '0;
    end

    // apply one accepted command to the shadow map, queue the color a read owes
    task automatic burn_step(input in_beat_t b);
        int pix;
        int below;
        int dec;
        int h;
        out_beat_t r;
        pix = b.pixel_pos;
        dec = b.decay;
        if (b.cmd == CMD_PROPAGATE) begin
            below = pix + MAP_W;
            if (below < MAP_CELLS) begin
                if (dec > DECAY_TOP)
                    dec = DECAY_TOP;
                h = heat_cells[below];
                h = (h >= dec) ? h - dec : 0;
                // write left of the pixel, dropped if it would fall before cell zero
                if (dec <= pix)
                    heat_cells[pix - dec] = h[HEAT_W-1:0];
            end
        end else begin
            h = (pix < MAP_CELLS) ? heat_cells[pix] : 0;
            r.heat = h[HEAT_W-1:0];
            if (h > HEAT_MAX)
                h = HEAT_MAX;
            {r.red, r.green, r.blue} = FLAME_RGB[h];
            color_reads.push_back(r);
        end
    endtask

    // monitor: results checked first, then the accepted command is predicted
    always @(posedge aclk) begin
        out_beat_t want;
        if (m_valid && m_ready) begin
            if (color_reads.size() == 0) begin
                if (fail_count < MAX_SHOWN)
                    $display("unexpected result beat heat=%0d rgb=%0d/%0d/%0d",
                             m_data.heat, m_data.red, m_data.green, m_data.blue);
                fail_count++;
            end else begin
                want = color_reads.pop_front();
                if (m_data.heat !== want.heat || m_data.red !== want.red ||
                    m_data.green !== want.green || m_data.blue !== want.blue) begin
                    if (fail_count < MAX_SHOWN)
                        $display("color mismatch: expected %0d %0d/%0d/%0d, got %0d %0d/%0d/%0d",
                                 want.heat, want.red, want.green, want.blue,
                                 m_data.heat, m_data.red, m_data.green, m_data.blue);
                    fail_count++;
                end
            end
        end
        if (s_valid && s_ready) begin
            burn_step(s_data);
            acc_count <= acc_count + 1;
        end
    end

    // driver: bursts of beats with random gaps, valid held until the beat is taken
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || acc_count == sent_count)) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                s_valid    <= 1'b1;
                s_data     <= pending_cmds.pop_front();
                sent_count <= sent_count + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns plus one long hold-off that backs up the input
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && acc_count >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 2));
                mode_left <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic push_cmd(input logic c, input int pix, input int dec);
        in_beat_t b;
        b.cmd       = c;
        b.pixel_pos = pix[PIX_W-1:0];
        b.decay     = dec[DECAY_W-1:0];
        pending_cmds.push_back(b);
    endtask

    // stimulus, reset and end of run
    initial begin
        int front;
        int row;
        int col;
        int len;
        int n_rd;
        int dec;

        // directed: corners, off-map, saturation, clamp and dropped writes
        push_cmd(CMD_READ, MAP_CELLS - 1, 0);           // bottom right, full heat
        push_cmd(CMD_READ, MAP_CELLS - MAP_W, 7);       // bottom left
        push_cmd(CMD_READ, 0, 0);                       // top left, cold
        push_cmd(CMD_READ, 2047, 7);                    // far off the map
        push_cmd(CMD_READ, MAP_CELLS, 0);               // first index past the map
        push_cmd(CMD_PROPAGATE, MAP_CELLS - MAP_W - 1, 0);
        push_cmd(CMD_READ, MAP_CELLS - MAP_W - 1, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - MAP_W - 1, 7); // decay saturates
        push_cmd(CMD_READ, MAP_CELLS - MAP_W - 5, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - MAP_W, 0);  // bottom row, no effect
        push_cmd(CMD_PROPAGATE, 2047, 7);               // off the map, no effect
        push_cmd(CMD_READ, MAP_CELLS - MAP_W, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - 2 * MAP_W, 1);
        push_cmd(CMD_READ, MAP_CELLS - 2 * MAP_W - 1, 0);
        push_cmd(CMD_PROPAGATE, 2, 4);                  // write index below zero
        push_cmd(CMD_PROPAGATE, 0, 1);                  // write index below zero
        push_cmd(CMD_PROPAGATE, 0, 0);
        push_cmd(CMD_READ, 0, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - MAP_W - 2, 3);
        push_cmd(CMD_READ, MAP_CELLS - MAP_W - 5, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - 2 * MAP_W - 5, 4);
        push_cmd(CMD_READ, MAP_CELLS - 2 * MAP_W - 9, 0);
        push_cmd(CMD_PROPAGATE, MAP_CELLS - 3 * MAP_W, 3); // cold source, clamps at zero
        push_cmd(CMD_READ, MAP_CELLS - 3 * MAP_W - 3, 0);

        // random: flame sweeps climbing up the map, reads nearby, some noise
        front = MAP_H - 2;
        while (pending_cmds.size() < RAND_ITEMS + 24) begin
            if ($urandom_range(0, 9) < 7) begin
                row = $urandom_range(front, MAP_H - 2);
                col = $urandom_range(0, MAP_W - 1);
                len = $urandom_range(6, 30);
                for (int k = 0; k < len; k++) begin
                    dec = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4);
                    push_cmd(CMD_PROPAGATE, row * MAP_W + col + k, dec);
                end
                n_rd = $urandom_range(2, 5);
                for (int k = 0; k < n_rd; k++)
                    push_cmd(CMD_READ, (row + $urandom_range(0, 1)) * MAP_W +
                             $urandom_range(0, MAP_W - 1), $urandom_range(0, 7));
                if (front > 0)
                    front--;
                else
                    front = MAP_H - 2;
            end else begin
                push_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                         $urandom_range(0, 7));
            end
        end
        n_items = pending_cmds.size();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (acc_count == n_items && color_reads.size() == 0);
        repeat (DRAIN) @(posedge aclk);

        if (fail_count == 0 && color_reads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run including the clearing pass
    initial begin
        #400us;
        $display("Verification failed");
        $finish;
    end

endmodule
